// ----- hw/rtl/sgb_pkg.sv -----
// Shared constants, types and helpers of the separable blur block.
package sgb_pkg;

  // Frame, kernel and pixel geometry
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned MaxTaps  = 7;
  localparam int unsigned MaxHalf  = (MaxTaps - 1) / 2;
  localparam int unsigned LineRows = MaxTaps - 1;
  localparam int unsigned NumCh    = 4;
  localparam int unsigned MaxChans = 4;

  // Field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned TapW     = 9;
  localparam int unsigned ColW     = 11;
  localparam int unsigned RowW     = 12;
  localparam int unsigned DimW     = 12;
  localparam int unsigned HalfW    = 2;
  localparam int unsigned ChanCntW = 3;
  localparam int unsigned CoeffW   = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned TapIdxW  = 3;
  localparam int unsigned ProdW    = TapW + PixW;
  localparam int unsigned AccW     = ProdW + 3;
  localparam int unsigned WordW    = NumCh * PixW;
  localparam int unsigned AddrW    = $clog2(MaxWidth);

  typedef logic [WordW-1:0] word_t;
  typedef logic [PixW-1:0]  pix_t;
  typedef logic [TapW-1:0]  tap_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCoeffs = 3'd0,
    CfgHalf   = 3'd1,
    CfgWidth  = 3'd2,
    CfgHeight = 3'd3,
    CfgChans  = 3'd4
  } cfg_idx_e;

  // One output job travelling down the pipeline
  typedef struct packed {
    logic [ColW-1:0]               col;
    logic [RowW-1:0]               row;
    logic [MaxTaps-1:0]            use_hv;
    logic [MaxTaps-1:0][SlotW-1:0] bank;
    logic [SlotW-1:0]              wslot;
    logic                          emit;
    logic                          last;
    logic                          fdone;
  } job_t;

  // Tap k of the packed coefficient word; taps past the kernel length are zero
  function automatic tap_t tap_get(logic [CoeffW-1:0] coeffs, logic [HalfW-1:0] half,
                                   int unsigned k);
    tap_t t;
    t = coeffs[TapW*k +: TapW];
    if (k > 2 * int'(half)) t = '0;
    return t;
  endfunction

endpackage

// ----- hw/rtl/sgb_ram.sv -----
// Generic single-write, single-read RAM with registered read (read-first).
module sgb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sgb_lane.sv -----
// One channel lane: tap multiplies, then the accumulate and scale stage.
module sgb_lane import sgb_pkg::*; (
  input  logic clk_i,
  input  logic mul_en_i,
  input  logic sum_en_i,
  input  pix_t pix_i  [MaxTaps],
  input  tap_t taps_i [MaxTaps],
  output pix_t res_o
);

  logic [ProdW-1:0] prod_q [MaxTaps];
  logic [AccW-1:0]  acc;
  pix_t             res_q;

  // Products, one per tap
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      for (int k = 0; k < MaxTaps; k++) begin
        prod_q[k] <= ProdW'(taps_i[k]) * ProdW'(pix_i[k]);
      end
    end
  end

  // Sum and keep bits 15..8
  always_comb begin
    acc = '0;
    for (int k = 0; k < MaxTaps; k++) begin
      acc = acc + AccW'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) res_q <= acc[2*PixW-1:PixW];
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/sgb_seq.sv -----
// Input side: pixel window, raster counters and the job sequencer with tap selection.
module sgb_seq import sgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [HalfW-1:0] half_i,
  input  logic [DimW-1:0]  width_i,
  input  logic [DimW-1:0]  height_i,
  input  logic             in_valid_i,
  input  word_t            in_word_i,
  output logic             in_stall_o,
  input  logic             s2_rdy_i,
  output logic             s1_vld_o,
  output word_t            s1_pix_o [MaxTaps],
  output job_t             s1_job_o
);

  localparam int unsigned SgnW = RowW + 2;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [SlotW-1:0] slot_q, slot_d;
  word_t            win_q [MaxTaps];

  logic             busy_q, busy_d;
  logic [ColW-1:0]  x_q, x_d, jc_q, jc_d, clo_q, clo_d, chi_q, chi_d;
  logic [RowW-1:0]  y_q, y_d, jr_q, jr_d, rhi_q, rhi_d;
  logic [SlotW-1:0] ysl_q, ysl_d;
  logic             emit_q, emit_d, lastc_q, lastc_d, lastr_q, lastr_d;

  logic             take, issue, last_job, s1_rdy;
  logic             last_col, last_row, col_ok, row_ok, any_col, any_row;
  logic [ColW-1:0]  c_lo, c_hi;
  logic [RowW-1:0]  r_lo, r_hi;

  logic             s1_vld_q;
  word_t            s1_pix_q [MaxTaps];
  job_t             s1_job_q;
  word_t            pix_sel [MaxTaps];
  job_t             job_sel;

  // Position of the arriving pixel and the output range it opens
  always_comb begin
    last_col = (DimW'(col_q) + DimW'(1)) >= width_i;
    last_row = ({1'b0, row_q} + 13'd1) >= {1'b0, height_i};
    col_ok   = col_q >= ColW'(half_i);
    row_ok   = row_q >= RowW'(half_i);
    any_col  = last_col || col_ok;
    any_row  = last_row || row_ok;
    c_lo     = col_ok ? col_q - ColW'(half_i) : '0;
    c_hi     = last_col ? col_q : col_q - ColW'(half_i);
    r_lo     = (any_row && row_ok) ? row_q - RowW'(half_i) : '0;
    r_hi     = !any_row ? '0 : (last_row ? row_q : row_q - RowW'(half_i));
  end

  // Handshake
  assign s1_rdy     = !s1_vld_q || s2_rdy_i;
  assign issue      = busy_q && s1_rdy;
  assign last_job   = (jc_q == chi_q) && (jr_q == rhi_q);
  assign in_stall_o = busy_q && !(issue && last_job);
  assign take       = in_valid_i && !in_stall_o;

  // Job walk: rows outer, columns inner
  always_comb begin
    busy_d  = busy_q;
    jc_d    = jc_q;
    jr_d    = jr_q;
    x_d     = x_q;
    y_d     = y_q;
    clo_d   = clo_q;
    chi_d   = chi_q;
    rhi_d   = rhi_q;
    ysl_d   = ysl_q;
    emit_d  = emit_q;
    lastc_d = lastc_q;
    lastr_d = lastr_q;
    col_d   = col_q;
    row_d   = row_q;
    slot_d  = slot_q;
    if (issue) begin
      if (last_job) begin
        busy_d = 1'b0;
      end else if (jc_q == chi_q) begin
        jc_d = clo_q;
        jr_d = jr_q + RowW'(1);
      end else begin
        jc_d = jc_q + ColW'(1);
      end
    end
    if (take) begin
      busy_d  = any_col;
      x_d     = col_q;
      y_d     = row_q;
      clo_d   = c_lo;
      chi_d   = c_hi;
      rhi_d   = r_hi;
      jc_d    = c_lo;
      jr_d    = r_lo;
      ysl_d   = slot_q;
      emit_d  = any_row;
      lastc_d = last_col;
      lastr_d = last_row;
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + RowW'(1);
          slot_d = (slot_q == SlotW'(LineRows - 1)) ? '0 : slot_q + SlotW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // Edge-replicated tap selection for both passes
  always_comb begin : sel
    logic signed [SgnW-1:0] kk, hs, vs, hx, vy;
    logic [SgnW-1:0]        hd, vd;
    logic [TapIdxW-1:0]     hidx, vj;
    job_sel        = '0;
    job_sel.col    = jc_q;
    job_sel.row    = jr_q;
    job_sel.wslot  = ysl_q;
    job_sel.emit   = emit_q;
    job_sel.last   = last_job && emit_q;
    job_sel.fdone  = last_job && emit_q && lastc_q && lastr_q;
    hx = $signed({3'b000, x_q});
    vy = $signed({2'b00, y_q});
    for (int k = 0; k < MaxTaps; k++) begin
      kk = SgnW'(k);
      hs = $signed({3'b000, jc_q}) + kk - $signed({{(SgnW-HalfW){1'b0}}, half_i});
      if (hs < 0) hs = '0;
      if (hs > hx) hs = hx;
      hd = hx - hs;
      hidx = (hd > SgnW'(MaxTaps - 1)) ? TapIdxW'(MaxTaps - 1) : hd[TapIdxW-1:0];
      pix_sel[k] = win_q[hidx];

      vs = $signed({2'b00, jr_q}) + kk - $signed({{(SgnW-HalfW){1'b0}}, half_i});
      if (vs < 0) vs = '0;
      if (vs > vy) vs = vy;
      vd = vy - vs;
      vj = (vd > SgnW'(LineRows)) ? TapIdxW'(LineRows) : vd[TapIdxW-1:0];
      job_sel.use_hv[k] = (vj == '0);
      job_sel.bank[k]   = (ysl_q >= SlotW'(vj)) ? ysl_q - SlotW'(vj)
                                                : ysl_q + SlotW'(LineRows) - SlotW'(vj);
    end
  end

  // Control and window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      busy_q   <= 1'b0;
      s1_vld_q <= 1'b0;
      for (int i = 0; i < MaxTaps; i++) win_q[i] <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
      busy_q <= busy_d;
      if (s1_rdy) s1_vld_q <= issue;
      if (take) begin
        win_q[0] <= in_word_i;
        for (int i = 1; i < MaxTaps; i++) win_q[i] <= win_q[i-1];
      end
    end
  end

  // Item context and stage-one payload
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    jc_q    <= jc_d;
    jr_q    <= jr_d;
    clo_q   <= clo_d;
    chi_q   <= chi_d;
    rhi_q   <= rhi_d;
    ysl_q   <= ysl_d;
    emit_q  <= emit_d;
    lastc_q <= lastc_d;
    lastr_q <= lastr_d;
    if (issue) begin
      s1_job_q <= job_sel;
      for (int k = 0; k < MaxTaps; k++) s1_pix_q[k] <= pix_sel[k];
    end
  end

  assign s1_vld_o = s1_vld_q;
  assign s1_pix_o = s1_pix_q;
  assign s1_job_o = s1_job_q;

endmodule

// ----- hw/rtl/separable_gaussian_blur.sv -----
// Separable blur top level: config registers, channel lanes, line store and output stage.
// Pixels arrive in raster order, one transaction per pixel with up to four 8-bit channels,
// and are filtered by 2*half+1 taps horizontally and then vertically, edges replicated.
// A pixel that opens k result columns and m result rows makes the job sequencer
// issue k*m jobs, one job per cycle while the stages downstream are ready (one job
// for an ordinary pixel, up to sixteen at the last pixel of a frame, where a whole
// run of results is flushed); one job per cycle is the sustained rate in the middle
// of a frame when nothing stalls. Each job goes through six stages: tap select,
// horizontal multiply, horizontal sum, line store access (six row banks read at the
// job's column while the current row's bank is written), vertical multiply and
// vertical sum. Four lanes, one per channel, run side by side in each pass. The user
// must write configuration only while idle; the block itself does not enforce it.
module separable_gaussian_blur import sgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoeffW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PixW-1:0]    sample_ch0_i,
  input  logic [PixW-1:0]    sample_ch1_i,
  input  logic [PixW-1:0]    sample_ch2_i,
  input  logic [PixW-1:0]    sample_ch3_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PixW-1:0]    blur_ch0_o,
  output logic [PixW-1:0]    blur_ch1_o,
  output logic [PixW-1:0]    blur_ch2_o,
  output logic [PixW-1:0]    blur_ch3_o,
  output logic [ColW-1:0]    out_col_o,
  output logic [RowW-1:0]    out_row_o,
  output logic               last_of_run_o,
  output logic               frame_done_o
);

  logic [CoeffW-1:0]   coeffs_q;
  logic [HalfW-1:0]    half_q, half_eff;
  logic [DimW-1:0]     width_q, height_q, w_eff, h_eff;
  logic [ChanCntW-1:0] chans_q, nch_eff;
  tap_t                taps [MaxTaps];

  logic  s1_vld;
  word_t s1_pix [MaxTaps];
  job_t  s1_job;

  logic  v2_q, v3_q, v4_q, v5_q, v6_q;
  logic  rdy2, rdy3, rdy4, rdy5, rdy6;
  logic  ld2, ld3, ld4, ld5, ld6;
  job_t  job2_q, job3_q, job4_q, job5_q, job6_q;
  word_t s4_hv_q, hv_word, vres_word, in_word;
  word_t rd_word [LineRows];
  word_t colv [MaxTaps];
  pix_t  hpix [NumCh][MaxTaps];
  pix_t  vpix [NumCh][MaxTaps];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_q <= 64'd16059453;
      half_q   <= HalfW'(1);
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
      chans_q  <= ChanCntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCoeffs: coeffs_q <= cfg_wdata_i;
        CfgHalf:   half_q   <= cfg_wdata_i[HalfW-1:0];
        CfgWidth:  width_q  <= cfg_wdata_i[DimW-1:0];
        CfgHeight: height_q <= cfg_wdata_i[DimW-1:0];
        CfgChans:  chans_q  <= cfg_wdata_i[ChanCntW-1:0];
        default: ;
      endcase
    end
  end

  // Register values as used: zero lifted to one, large half, width and channel values saturated
  always_comb begin
    half_eff = (half_q == '0) ? HalfW'(1)
             : ((half_q > HalfW'(MaxHalf)) ? HalfW'(MaxHalf) : half_q);
    w_eff    = (width_q == '0) ? DimW'(1)
             : ((width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q);
    h_eff    = (height_q == '0) ? DimW'(1) : height_q;
    nch_eff  = (chans_q == '0) ? ChanCntW'(1)
             : ((chans_q > ChanCntW'(MaxChans)) ? ChanCntW'(MaxChans) : chans_q);
    for (int k = 0; k < MaxTaps; k++) taps[k] = tap_get(coeffs_q, half_eff, k);
  end

  assign in_word = {sample_ch3_i, sample_ch2_i, sample_ch1_i, sample_ch0_i};

  // Input window and job sequencer
  sgb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .half_i     (half_eff),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word),
    .in_stall_o (in_stall_o),
    .s2_rdy_i   (rdy2),
    .s1_vld_o   (s1_vld),
    .s1_pix_o   (s1_pix),
    .s1_job_o   (s1_job)
  );

  // Elastic stage handshakes; bubbles collapse
  assign rdy6 = !v6_q || !out_stall_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign ld2  = s1_vld && rdy2;
  assign ld3  = v2_q && rdy3;
  assign ld4  = v3_q && rdy4;
  assign ld5  = v4_q && rdy5;
  assign ld6  = v5_q && rdy6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= s1_vld;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      // store-only jobs end after the line store access
      if (rdy5) v5_q <= v4_q && job4_q.emit;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // Job sideband along the stages
  always_ff @(posedge clk_i) begin
    if (ld2) job2_q <= s1_job;
    if (ld3) job3_q <= job2_q;
    if (ld4) begin
      job4_q  <= job3_q;
      s4_hv_q <= hv_word;
    end
    if (ld5) job5_q <= job4_q;
    if (ld6) job6_q <= job5_q;
  end

  // Lane inputs, split by channel
  always_comb begin
    for (int k = 0; k < MaxTaps; k++) begin
      colv[k] = job4_q.use_hv[k] ? s4_hv_q : rd_word[job4_q.bank[k]];
    end
    for (int ch = 0; ch < NumCh; ch++) begin
      for (int k = 0; k < MaxTaps; k++) begin
        hpix[ch][k] = s1_pix[k][ch*PixW +: PixW];
        vpix[ch][k] = colv[k][ch*PixW +: PixW];
      end
    end
  end

  // Channel lanes, horizontal and vertical
  for (genvar ch = 0; ch < NumCh; ch++) begin : g_lane
    sgb_lane u_hlane (
      .clk_i    (clk_i),
      .mul_en_i (ld2),
      .sum_en_i (ld3),
      .pix_i    (hpix[ch]),
      .taps_i   (taps),
      .res_o    (hv_word[ch*PixW +: PixW])
    );
    sgb_lane u_vlane (
      .clk_i    (clk_i),
      .mul_en_i (ld5),
      .sum_en_i (ld6),
      .pix_i    (vpix[ch]),
      .taps_i   (taps),
      .res_o    (vres_word[ch*PixW +: PixW])
    );
  end

  // Line store: one bank per buffered row, read-first at the job's column
  for (genvar b = 0; b < LineRows; b++) begin : g_bank
    sgb_ram #(
      .Width (WordW),
      .Depth (MaxWidth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ld4 && (job3_q.wslot == SlotW'(b))),
      .waddr_i (job3_q.col[AddrW-1:0]),
      .wdata_i (hv_word),
      .re_i    (ld4),
      .raddr_i (job3_q.col[AddrW-1:0]),
      .rdata_o (rd_word[b])
    );
  end

  // Output merge: unused channels read as zero
  assign out_valid_o   = v6_q;
  assign blur_ch0_o    = (nch_eff > ChanCntW'(0)) ? vres_word[0*PixW +: PixW] : '0;
  assign blur_ch1_o    = (nch_eff > ChanCntW'(1)) ? vres_word[1*PixW +: PixW] : '0;
  assign blur_ch2_o    = (nch_eff > ChanCntW'(2)) ? vres_word[2*PixW +: PixW] : '0;
  assign blur_ch3_o    = (nch_eff > ChanCntW'(3)) ? vres_word[3*PixW +: PixW] : '0;
  assign out_col_o     = job6_q.col;
  assign out_row_o     = job6_q.row;
  assign last_of_run_o = job6_q.last;
  assign frame_done_o  = job6_q.fdone;

endmodule
